// File: rtl/channel_throughput_meter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the channel throughput meter
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_THROUGHPUT_METER_ASSERT_SVH
`define CHANNEL_THROUGHPUT_METER_ASSERT_SVH

// same-cycle implication
`define CTM_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CTM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ctm_pkg.sv
// ----------------------------------------------------------------------------
// ctm_pkg
// Shared constants and types of the channel throughput meter.
// ----------------------------------------------------------------------------
package ctm_pkg;

	localparam int DATA_W       = 32;
	localparam int TICK_SHIFT   = 15;
	localparam int SECS_W       = DATA_W - TICK_SHIFT;
	localparam int SLOT_OUT_W   = 3;
	localparam int CHANNELS_DEF = 2;
	localparam int HISTORY_DEF  = 8;

	localparam logic [DATA_W-1:0] THRESH_RESET = 32'd163840;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [SECS_W-1:0] divisor;
	} div_req_t;

endpackage

// File: rtl/ctm_if.sv
// ----------------------------------------------------------------------------
// ctm_if
// Valid/ready channels of the channel throughput meter.
// ----------------------------------------------------------------------------
interface ctm_event_if import ctm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              channel;
	logic [DATA_W-1:0] byte_count;
	logic [DATA_W-1:0] time_stamp;

	modport source (output valid, channel, byte_count, time_stamp, input ready);
	modport sink (input valid, channel, byte_count, time_stamp, output ready);
endinterface

interface ctm_result_if import ctm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  recorded;
	logic                  restarted;
	logic [SLOT_OUT_W-1:0] slot;
	logic [DATA_W-1:0]     throughput;
	logic [DATA_W-1:0]     channel_peak;
	logic [DATA_W-1:0]     latest_rate;

	modport source (output valid, recorded, restarted, slot, throughput, channel_peak,
		latest_rate, input ready);
	modport sink (input valid, recorded, restarted, slot, throughput, channel_peak,
		latest_rate, output ready);
endinterface

interface ctm_cfg_if import ctm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: rtl/channel_throughput_meter.sv
// ----------------------------------------------------------------------------
// channel_throughput_meter
// Per-channel byte accounting with throughput history and peak tracking.
// ----------------------------------------------------------------------------
// event_ch carries one transaction per event: channel, byte_count and a
// 32768 Hz time_stamp. result_ch returns one transaction per event with the
// recorded flag, restart flag, history slot, throughput, channel peak and the
// newest history value. cfg writes interval_threshold and is always ready.
// The user must see that it is written only while no event is in flight;
// the block does not enforce this. An event passes from acceptance through
// S_READ, S_HIST, S_DIV when a division runs (a recording with a nonzero
// seconds count, where the bit-serial divider computes bytes / seconds) and
// S_WB to the output register. A new event is accepted only in S_IDLE, at
// the earliest in the cycle after the write-back. Channel state and history
// sit in two synchronous memories with registered reads. After reset, a
// clearing pass writes zero to the CHANNELS*HISTORY history entries, one per
// cycle, and to the CHANNELS channel entries, with event_ch held not ready;
// the threshold returns to 163840. A stalled result stays in its register;
// the next event is accepted meanwhile, its write-back waiting till it frees.
// ----------------------------------------------------------------------------
module channel_throughput_meter import ctm_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int HISTORY  = HISTORY_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	ctm_event_if.sink    event_ch,
	ctm_result_if.source result_ch,
	ctm_cfg_if.sink      cfg
);

	`include "channel_throughput_meter_assert.svh"

	localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W     = $clog2(HISTORY);
	localparam int HIST_DEPTH = CHANNELS * HISTORY;
	localparam int HADDR_W    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_HIST = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_WB   = 3'd4;

	typedef struct packed {
		logic [DATA_W-1:0] stamp;
		logic [DATA_W-1:0] total;
		logic [DATA_W-1:0] peak;
		logic [SLOT_W-1:0] nslot;
	} chan_word_t;

	chan_word_t        chan_mem [CHANNELS];
	logic [DATA_W-1:0] hist_mem [HIST_DEPTH];

	logic [2:0]         state_q;
	logic               clr_busy_q;
	logic [HADDR_W-1:0] clr_cnt_q;
	logic [DATA_W-1:0]  thresh_q;

	logic [CH_AW-1:0]   ch_q;
	logic               inrange_q;
	logic [DATA_W-1:0]  bytes_q;
	logic [DATA_W-1:0]  now_q;
	chan_word_t         chan_rd_q;
	logic [DATA_W-1:0]  hist_rd_q;
	logic [DATA_W-1:0]  tot_q;
	logic               back_q;
	logic               rec_q;
	logic [SECS_W-1:0]  secs_q;
	logic [DATA_W-1:0]  rate_q;

	logic                  out_valid_q;
	logic                  out_rec_q;
	logic                  out_rst_q;
	logic [SLOT_OUT_W-1:0] out_slot_q;
	logic [DATA_W-1:0]     out_tput_q;
	logic [DATA_W-1:0]     out_peak_q;
	logic [DATA_W-1:0]     out_latest_q;

	logic               accept;
	logic               wb_go;
	logic [CH_AW-1:0]   ch_in;
	logic               ch_in_ok;
	logic [DATA_W:0]    sum;
	logic [DATA_W-1:0]  tot_sat;
	logic               back;
	logic [DATA_W-1:0]  elapsed;
	logic [SLOT_W-1:0]  prev_slot;
	logic [SLOT_W-1:0]  next_slot;
	logic [HADDR_W-1:0] hist_rd_addr;
	logic [HADDR_W-1:0] hist_wr_addr;
	logic [DATA_W-1:0]  new_peak;
	div_req_t           div_req;
	logic               div_done;
	logic [DATA_W-1:0]  div_quo;

	assign ch_in_ok = 32'(event_ch.channel) < 32'(CHANNELS);
	assign ch_in    = ch_in_ok ? CH_AW'(event_ch.channel) : '0;
	assign accept   = event_ch.valid && event_ch.ready;
	assign wb_go    = (state_q == S_WB) && (!out_valid_q || result_ch.ready);

	assign event_ch.ready = (state_q == S_IDLE) && !clr_busy_q;
	assign cfg.ready      = 1'b1;

	assign sum     = {1'b0, chan_rd_q.total} + {1'b0, bytes_q};
	assign tot_sat = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
	assign back    = now_q < chan_rd_q.stamp;
	assign elapsed = now_q - chan_rd_q.stamp;

	assign prev_slot = (chan_rd_q.nslot == '0) ? SLOT_W'(HISTORY - 1)
		: chan_rd_q.nslot - 1'b1;
	assign next_slot = (chan_rd_q.nslot == SLOT_W'(HISTORY - 1)) ? '0
		: chan_rd_q.nslot + 1'b1;

	assign hist_rd_addr = HADDR_W'(ch_q) * HADDR_W'(HISTORY) + HADDR_W'(prev_slot);
	assign hist_wr_addr = HADDR_W'(ch_q) * HADDR_W'(HISTORY) + HADDR_W'(chan_rd_q.nslot);
	assign new_peak     = (rate_q > chan_rd_q.peak) ? rate_q : chan_rd_q.peak;

	assign div_req.start    = (state_q == S_HIST) && rec_q && (secs_q != '0);
	assign div_req.dividend = tot_q;
	assign div_req.divisor  = secs_q;

	ctm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// control: sequencer, clearing pass, threshold, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clr_busy_q  <= 1'b1;
			clr_cnt_q   <= '0;
			thresh_q    <= THRESH_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				thresh_q <= cfg.data;
			end
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == HADDR_W'(HIST_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (wb_go) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.valid && result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_HIST;
				end
				S_HIST: begin
					state_q <= div_req.start ? S_DIV : S_WB;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (wb_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q      <= ch_in;
			inrange_q <= ch_in_ok;
			bytes_q   <= event_ch.byte_count;
			now_q     <= event_ch.time_stamp;
			chan_rd_q <= chan_mem[ch_in];
		end
		if (state_q == S_READ) begin
			hist_rd_q <= hist_mem[hist_rd_addr];
			tot_q     <= tot_sat;
			back_q    <= back;
			rec_q     <= !back && (elapsed > thresh_q);
			secs_q    <= elapsed[DATA_W-1:TICK_SHIFT];
		end
		if (state_q == S_HIST) begin
			rate_q <= '1;
		end
		if (state_q == S_DIV && div_done) begin
			rate_q <= div_quo;
		end
		if (wb_go) begin
			out_rec_q    <= inrange_q && rec_q;
			out_rst_q    <= inrange_q && back_q;
			out_slot_q   <= (inrange_q && rec_q) ? SLOT_OUT_W'(chan_rd_q.nslot) : '0;
			out_tput_q   <= (inrange_q && rec_q) ? rate_q : '0;
			out_peak_q   <= !inrange_q ? '0 : (rec_q ? new_peak : chan_rd_q.peak);
			out_latest_q <= !inrange_q ? '0 : (rec_q ? rate_q : hist_rd_q);
		end
	end

	// memories: clearing pass, then write-back
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			hist_mem[clr_cnt_q] <= '0;
			if (32'(clr_cnt_q) < 32'(CHANNELS)) begin
				chan_mem[CH_AW'(clr_cnt_q)] <= '0;
			end
		end else if (wb_go && inrange_q) begin
			if (back_q) begin
				chan_mem[ch_q] <= '{stamp: now_q, total: '0, peak: chan_rd_q.peak,
					nslot: chan_rd_q.nslot};
			end else if (rec_q) begin
				hist_mem[hist_wr_addr] <= rate_q;
				chan_mem[ch_q] <= '{stamp: now_q, total: '0, peak: new_peak,
					nslot: next_slot};
			end else begin
				chan_mem[ch_q] <= '{stamp: chan_rd_q.stamp, total: tot_q,
					peak: chan_rd_q.peak, nslot: chan_rd_q.nslot};
			end
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.recorded     = out_rec_q;
	assign result_ch.restarted    = out_rst_q;
	assign result_ch.slot         = out_slot_q;
	assign result_ch.throughput   = out_tput_q;
	assign result_ch.channel_peak = out_peak_q;
	assign result_ch.latest_rate  = out_latest_q;

	`CTM_ASSERT_IMPLY(a_clear_blocks_events, clr_busy_q, !event_ch.ready,
		"event accepted during clearing pass")
	`CTM_ASSERT_NEXT(a_accept_reads, accept, state_q == S_READ,
		"accepted event did not start a read")
	`CTM_ASSERT_IMPLY(a_rec_rst_exclusive, out_valid_q, !(out_rec_q && out_rst_q),
		"result both recorded and restarted")
	`CTM_ASSERT_IMPLY(a_idle_fields_zero, out_valid_q && !out_rec_q,
		(out_slot_q == '0) && (out_tput_q == '0), "slot or throughput set without record")
	`CTM_ASSERT_IMPLY(a_div_only_in_div, div_done, state_q == S_DIV,
		"divider finished outside divide state")

endmodule

// File: rtl/ctm_div.sv
// ----------------------------------------------------------------------------
// ctm_div
// Restoring divider, one quotient bit per cycle, done pulses when the last bit is in.
// ----------------------------------------------------------------------------
module ctm_div import ctm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SECS_W-1:0] rem_q;
	logic [SECS_W-1:0] dvs_q;
	logic [DATA_W-1:0] quo_q;
	logic [SECS_W:0]   trial;
	logic [SECS_W:0]   diff;
	logic              fits;

	assign trial = {rem_q, quo_q[DATA_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[SECS_W-1:0] : trial[SECS_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: sim/ctm_meter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ctm_meter_checker
// Watches the event, result and configuration channels of the channel
// throughput meter. Each accepted event updates a local copy of the per-channel
// byte totals, stamps, peaks and history rings, and the predicted result is
// queued. Each accepted result is compared field by field with the oldest
// prediction. The failure count, the number of outstanding predictions and
// the counts of results, recordings and restarts go back to the testbench top.
// ----------------------------------------------------------------------------
module ctm_meter_checker import ctm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ev_valid,
	input  logic              ev_ready,
	input  logic              ev_channel,
	input  logic [DATA_W-1:0] ev_byte_count,
	input  logic [DATA_W-1:0] ev_time_stamp,
	input  logic              res_valid,
	input  logic              res_ready,
	input  logic              res_recorded,
	input  logic              res_restarted,
	input  logic [SLOT_OUT_W-1:0] res_slot,
	input  logic [DATA_W-1:0] res_throughput,
	input  logic [DATA_W-1:0] res_channel_peak,
	input  logic [DATA_W-1:0] res_latest_rate,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [DATA_W-1:0] cfg_data,
	output int                fail_count,
	output int                pending,
	output int                results,
	output int                recordings,
	output int                restarts
);

	typedef struct packed {
		logic                  recorded;
		logic                  restarted;
		logic [SLOT_OUT_W-1:0] slot;
		logic [DATA_W-1:0]     throughput;
		logic [DATA_W-1:0]     channel_peak;
		logic [DATA_W-1:0]     latest_rate;
	} meter_result_t;

	logic [DATA_W-1:0] interval;
	logic [DATA_W-1:0] stamp_q [CHANNELS_DEF];
	logic [DATA_W-1:0] byte_sum [CHANNELS_DEF];
	logic [DATA_W-1:0] peak_q [CHANNELS_DEF];
	int                wr_slot [CHANNELS_DEF];
	logic [DATA_W-1:0] ring_rate [CHANNELS_DEF][HISTORY_DEF];

	meter_result_t expected_results [$];
	meter_result_t want;

	function automatic meter_result_t predict_meter(logic ch, logic [DATA_W-1:0] nbytes,
		logic [DATA_W-1:0] now);
		meter_result_t     r;
		logic [DATA_W:0]   sum;
		logic [DATA_W-1:0] elapsed;
		logic [SECS_W-1:0] secs;
		logic [DATA_W-1:0] rate;
		int                c;
		int                s;
		int                prev;
		r = '0;
		c = int'(ch);
		sum = {1'b0, byte_sum[c]} + {1'b0, nbytes};
		byte_sum[c] = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
		if (now >= stamp_q[c]) begin
			elapsed = now - stamp_q[c];
			if (elapsed > interval) begin
				secs = elapsed[DATA_W-1:TICK_SHIFT];
				s = wr_slot[c];
				rate = (secs == '0) ? '1 : byte_sum[c] / secs;
				ring_rate[c][s] = rate;
				stamp_q[c] = now;
				if (rate > peak_q[c])
					peak_q[c] = rate;
				wr_slot[c] = (s + 1 >= HISTORY_DEF) ? 0 : s + 1;
				byte_sum[c] = '0;
				r.recorded = 1'b1;
				r.slot = s[SLOT_OUT_W-1:0];
				r.throughput = rate;
			end
		end else begin
			stamp_q[c] = now;
			byte_sum[c] = '0;
			r.restarted = 1'b1;
		end
		prev = (wr_slot[c] == 0) ? HISTORY_DEF - 1 : wr_slot[c] - 1;
		r.channel_peak = peak_q[c];
		r.latest_rate = ring_rate[c][prev];
		return r;
	endfunction

	task automatic check_field(string name, logic [DATA_W-1:0] exp_val,
		logic [DATA_W-1:0] got_val);
		if (exp_val !== got_val) begin
			if (fail_count < 10)
				$display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, name,
					exp_val, got_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval = THRESH_RESET;
			for (int c = 0; c < CHANNELS_DEF; c++) begin
				stamp_q[c] = '0;
				byte_sum[c] = '0;
				peak_q[c] = '0;
				wr_slot[c] = 0;
				for (int h = 0; h < HISTORY_DEF; h++)
					ring_rate[c][h] = '0;
			end
			expected_results.delete();
			fail_count = 0;
			pending = 0;
			results = 0;
			recordings = 0;
			restarts = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				interval = cfg_data;
			if (res_valid && res_ready) begin
				results++;
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("[%0t] result with nothing predicted: rec=%0b rst=%0b rate=%0h",
							$realtime, res_recorded, res_restarted, res_throughput);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("recorded", DATA_W'(want.recorded), DATA_W'(res_recorded));
					check_field("restarted", DATA_W'(want.restarted), DATA_W'(res_restarted));
					check_field("slot", DATA_W'(want.slot), DATA_W'(res_slot));
					check_field("throughput", want.throughput, res_throughput);
					check_field("channel_peak", want.channel_peak, res_channel_peak);
					check_field("latest_rate", want.latest_rate, res_latest_rate);
					if (want.recorded)
						recordings++;
					if (want.restarted)
						restarts++;
				end
			end
			if (ev_valid && ev_ready)
				expected_results.push_back(predict_meter(ev_channel, ev_byte_count,
					ev_time_stamp));
			pending = expected_results.size();
		end
	end

endmodule

// File: sim/tb_channel_throughput_meter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_channel_throughput_meter
// Drives byte-count events into the channel throughput meter and rewrites the
// interval threshold between phases. A directed opening covers equal and
// backward stamps, saturation, history wrap and a zero seconds count; random
// phases follow under several thresholds and three back-pressure profiles.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_channel_throughput_meter;
	import ctm_pkg::*;

	localparam int RANDOM_EVENTS = 800;
	localparam int PHASES        = 8;
	localparam int EVENT_TOTAL   = RANDOM_EVENTS + 22;
	localparam int CYCLE_LIMIT   = 400000;

	logic              clk;
	logic              arst_n;
	int                send_idle;
	int                recv_idle;
	int                sent;
	int                thr_writes;
	int                cycles = 0;
	int                fail_count;
	int                pending;
	int                results;
	int                recordings;
	int                restarts;
	logic [DATA_W-1:0] cur_thr;
	logic [DATA_W-1:0] last_ts [CHANNELS_DEF];
	logic [DATA_W-1:0] thr_plan [PHASES];

	ctm_event_if  ev_if ();
	ctm_result_if res_if ();
	ctm_cfg_if    cfg_if ();

	channel_throughput_meter #(
		.CHANNELS(CHANNELS_DEF),
		.HISTORY (HISTORY_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.event_ch (ev_if),
		.result_ch(res_if),
		.cfg      (cfg_if)
	);

	ctm_meter_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.ev_valid        (ev_if.valid),
		.ev_ready        (ev_if.ready),
		.ev_channel      (ev_if.channel),
		.ev_byte_count   (ev_if.byte_count),
		.ev_time_stamp   (ev_if.time_stamp),
		.res_valid       (res_if.valid),
		.res_ready       (res_if.ready),
		.res_recorded    (res_if.recorded),
		.res_restarted   (res_if.restarted),
		.res_slot        (res_if.slot),
		.res_throughput  (res_if.throughput),
		.res_channel_peak(res_if.channel_peak),
		.res_latest_rate (res_if.latest_rate),
		.cfg_valid       (cfg_if.valid),
		.cfg_ready       (cfg_if.ready),
		.cfg_data        (cfg_if.data),
		.fail_count      (fail_count),
		.pending         (pending),
		.results         (results),
		.recordings      (recordings),
		.restarts        (restarts)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		res_if.ready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	task automatic send_event(logic ch, logic [DATA_W-1:0] nbytes, logic [DATA_W-1:0] ts);
		if (sent * 3 < EVENT_TOTAL) begin
			send_idle = 8;
			recv_idle = 64;
		end else if (sent * 3 < 2 * EVENT_TOTAL) begin
			send_idle = 64;
			recv_idle = 8;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
		while ($urandom_range(99) < send_idle) begin
			ev_if.valid <= 1'b0;
			@(negedge clk);
		end
		ev_if.valid <= 1'b1;
		ev_if.channel <= ch;
		ev_if.byte_count <= nbytes;
		ev_if.time_stamp <= ts;
		@(posedge clk);
		while (!ev_if.ready)
			@(posedge clk);
		last_ts[ch] = ts;
		sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		ev_if.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_threshold(logic [DATA_W-1:0] value);
		drain_results();
		cfg_if.valid <= 1'b1;
		cfg_if.data <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		cur_thr = value;
		thr_writes++;
	endtask

	task automatic next_event();
		logic              ch;
		logic [DATA_W-1:0] span;
		logic [DATA_W-1:0] ts;
		logic [DATA_W-1:0] nbytes;
		int                kind;
		ch = $urandom_range(1, 0);
		kind = $urandom_range(99);
		if (cur_thr >= 32'h4000_0000)
			span = $urandom;
		else
			span = $urandom_range(2 * cur_thr + 2, cur_thr / 2);
		if (kind < 72)
			ts = last_ts[ch] + span;
		else if (kind < 80)
			ts = last_ts[ch];
		else if (kind < 90)
			ts = last_ts[ch] - ($urandom_range(65535) + 1);
		else
			ts = $urandom;
		case ($urandom_range(3))
			0: nbytes = $urandom;
			1: nbytes = $urandom_range(100000);
			2: nbytes = $urandom | 32'hF000_0000;
			default: nbytes = $urandom_range(1) ? '1 : '0;
		endcase
		send_event(ch, nbytes, ts);
	endtask

	initial begin
		arst_n = 1'b0;
		ev_if.valid = 1'b0;
		ev_if.channel = 1'b0;
		ev_if.byte_count = '0;
		ev_if.time_stamp = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		cur_thr = THRESH_RESET;
		last_ts = '{default: '0};
		sent = 0;
		thr_writes = 0;
		send_idle = 8;
		recv_idle = 64;
		thr_plan = '{32'd32768, 32'd163840, 32'd1000, 32'hFFFF_FFFF, 32'd0, 32'd20000,
			32'd0, 32'd32768};
		thr_plan[4] = $urandom_range(4000000, 32768);
		thr_plan[6] = $urandom_range(1 << 20, 32768);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_event(1'b0, 32'd0, 32'd0);
		send_event(1'b0, 32'd1000, 32'd163840);
		send_event(1'b0, 32'd5000, 32'd163841);
		send_event(1'b1, '1, '1);
		send_event(1'b1, '1, '1);
		send_event(1'b1, '1, '1);
		send_event(1'b1, 32'd5, 32'd100);
		send_event(1'b0, 32'd0, 32'd10);
		for (int i = 1; i <= 9; i++)
			send_event(1'b0, $urandom, 32'd10 + i * 200000);
		write_threshold(32'd100);
		send_event(1'b0, 32'd12345, last_ts[0] + 32'd200);
		send_event(1'b1, '1, last_ts[1] + 32'd101);
		write_threshold(32'd32768);
		send_event(1'b0, 32'd777, last_ts[0] + 32'd32769);
		write_threshold('1);
		send_event(1'b1, 32'd9, '1);
		send_event(1'b1, 32'd3, 32'd0);

		for (int p = 0; p < PHASES; p++) begin
			write_threshold(thr_plan[p]);
			repeat (RANDOM_EVENTS / PHASES)
				next_event();
		end

		drain_results();
		repeat (40) @(posedge clk);
		$display("Summary: %0d events sent, %0d results checked, %0d recordings, %0d restarts",
			sent, results, recordings, restarts);
		$display("Summary: %0d threshold writes under three back-pressure profiles",
			thr_writes);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
